// ===== src/plv_pkg.sv =====
// Shared types and constants for the peer liveness table.
package plv_pkg;

	localparam int ENTRIES    = 16;
	localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_OUT_W = 4;
	localparam int ADDR_W     = 64;
	localparam int TIME_W     = 32;
	localparam int TMO_W      = 16;

	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd30;

	typedef enum logic [1:0] {
		MODE_HEARTBEAT = 2'd0,
		MODE_EXIT      = 2'd1,
		MODE_OTHER     = 2'd2,
		MODE_SWEEP     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_REFRESHED    = 3'd0,
		ST_ADDED        = 3'd1,
		ST_EXIT_REMOVED = 3'd2,
		ST_EXIT_UNKNOWN = 3'd3,
		ST_IGNORED      = 3'd4,
		ST_FULL         = 3'd5,
		ST_DROPPED      = 3'd6,
		ST_SWEEP_DONE   = 3'd7
	} status_t;

	// Query token walking the cell chain. hit_slot is the matched slot for
	// heartbeat/exit, or the dropping cell on a sweep.
	typedef struct packed {
		logic              vld;
		mode_t             mode;
		logic [ADDR_W-1:0] addr_hi;
		logic [ADDR_W-1:0] addr_lo;
		logic [TIME_W-1:0] now;
		logic              found;
		logic [SLOT_W-1:0] hit_slot;
		logic              free;
		logic [SLOT_W-1:0] free_slot;
		logic              drop;
	} tok_t;

	// New-peer write data, broadcast to all cells.
	typedef struct packed {
		logic [ADDR_W-1:0] addr_hi;
		logic [ADDR_W-1:0] addr_lo;
		logic [TIME_W-1:0] now;
	} wr_t;

endpackage

// ===== src/plv_if.sv =====
// Handshake channels of the peer liveness table.
interface plv_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] peer_addr_high;
	logic [63:0] peer_addr_low;
	logic [31:0] now_seconds;
	modport source (output valid, mode, peer_addr_high, peer_addr_low, now_seconds,
		input ready);
	modport sink (input valid, mode, peer_addr_high, peer_addr_low, now_seconds,
		output ready);
endinterface

interface plv_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] slot;
	logic       last;
	modport source (output valid, status, slot, last, input ready);
	modport sink (input valid, status, slot, last, output ready);
endinterface

interface plv_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] timeout_seconds;
	modport source (output valid, timeout_seconds, input ready);
	modport sink (input valid, timeout_seconds, output ready);
endinterface

// ===== src/plv_cell.sv =====
// One table slot: holds a peer entry and evaluates the passing query token.
module plv_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [plv_pkg::SLOT_W-1:0] idx,
	input  logic                       advance,
	input  logic [plv_pkg::TMO_W-1:0]  timeout,
	input  plv_pkg::tok_t              tok_in,
	input  logic                       wr_en,
	input  plv_pkg::wr_t               wr,
	output plv_pkg::tok_t              tok_out
);

	logic                        valid_q;
	logic [plv_pkg::ADDR_W-1:0]  addr_hi_q;
	logic [plv_pkg::ADDR_W-1:0]  addr_lo_q;
	logic [plv_pkg::TIME_W-1:0]  heard_q;
	plv_pkg::tok_t               tok_q;
	plv_pkg::tok_t               tok_d;
	logic                        match;
	logic                        expired;
	logic                        refresh;
	logic                        clear;

	assign match = valid_q && !tok_in.found
		&& (addr_hi_q == tok_in.addr_hi) && (addr_lo_q == tok_in.addr_lo);

	// last_heard + timeout < now, without wrap
	assign expired = ({1'b0, heard_q} + {{(plv_pkg::TIME_W - plv_pkg::TMO_W + 1){1'b0}}, timeout})
		< {1'b0, tok_in.now};

	always_comb begin
		tok_d   = tok_in;
		tok_d.drop = 1'b0;
		refresh = 1'b0;
		clear   = 1'b0;
		if (tok_in.vld) begin
			case (tok_in.mode)
				plv_pkg::MODE_HEARTBEAT: begin
					if (match) begin
						tok_d.found    = 1'b1;
						tok_d.hit_slot = idx;
						refresh        = 1'b1;
					end else if (!valid_q && !tok_in.free) begin
						tok_d.free      = 1'b1;
						tok_d.free_slot = idx;
					end
				end
				plv_pkg::MODE_EXIT: begin
					if (match) begin
						tok_d.found    = 1'b1;
						tok_d.hit_slot = idx;
						clear          = 1'b1;
					end
				end
				plv_pkg::MODE_SWEEP: begin
					if (valid_q && expired) begin
						tok_d.drop     = 1'b1;
						tok_d.hit_slot = idx;
						clear          = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			if (advance) begin
				tok_q <= tok_d;
				if (clear)
					valid_q <= 1'b0;
			end
			if (wr_en)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_hi_q <= wr.addr_hi;
			addr_lo_q <= wr.addr_lo;
			heard_q   <= wr.now;
		end else if (advance && refresh) begin
			heard_q <= tok_in.now;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== src/peer_liveness_table.sv =====
// Top level of the peer liveness table: cell chain, control and result register.
//
//  channel | dir | payload                                       | accepted when
//  req     | in  | mode, peer_addr_high, peer_addr_low, now_seconds | valid && ready
//  rsp     | out | status, slot, last                             | valid && ready
//  cfg     | in  | timeout_seconds                                | valid && ready
//
// An item enters a head register and a query token then steps through the
// ENTRIES cells and a tail register, one stage per cycle while not stalled;
// req is ready again the cycle after the token leaves the tail register.
// The whole chain stalls while the result register holds an untaken item.
// Reset empties the table at once (valid bits only) and loads timeout 30.
module peer_liveness_table (
	input logic          clk,
	input logic          arst_n,
	plv_req_if.sink      req,
	plv_rsp_if.source    rsp,
	plv_cfg_if.sink      cfg
);

	plv_pkg::tok_t                head_q;
	plv_pkg::tok_t                tail_q;
	plv_pkg::tok_t                cell_tok [plv_pkg::ENTRIES];
	logic [plv_pkg::ENTRIES-1:0]  cell_vld;
	logic [plv_pkg::ENTRIES-1:0]  wr_en;
	plv_pkg::wr_t                 wr;
	logic [plv_pkg::TMO_W-1:0]    timeout_q;
	logic                         busy_q;
	logic                         advance;
	logic                         accept;
	logic                         drop_any;
	logic [plv_pkg::SLOT_W-1:0]   drop_slot;
	logic                         add_new;
	plv_pkg::status_t             fin_status;
	logic [plv_pkg::SLOT_W-1:0]   fin_slot;
	logic                         out_vld_q;
	plv_pkg::status_t             status_q;
	logic [plv_pkg::SLOT_OUT_W-1:0] slot_q;
	logic                         last_q;

	assign advance = !out_vld_q || rsp.ready;
	assign req.ready = !busy_q;
	assign accept = req.valid && !busy_q;
	assign cfg.ready = 1'b1;

	genvar gi;
	generate
		for (gi = 0; gi < plv_pkg::ENTRIES; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				plv_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.idx     (plv_pkg::SLOT_W'(gi)),
					.advance (advance),
					.timeout (timeout_q),
					.tok_in  (head_q),
					.wr_en   (wr_en[gi]),
					.wr      (wr),
					.tok_out (cell_tok[gi])
				);
			end else begin : g_next
				plv_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.idx     (plv_pkg::SLOT_W'(gi)),
					.advance (advance),
					.timeout (timeout_q),
					.tok_in  (cell_tok[gi-1]),
					.wr_en   (wr_en[gi]),
					.wr      (wr),
					.tok_out (cell_tok[gi])
				);
			end
			assign cell_vld[gi] = cell_tok[gi].vld;
		end
	endgenerate

	// Only one token is in flight, so an OR over the cells picks its drop.
	always_comb begin
		drop_any  = 1'b0;
		drop_slot = '0;
		for (int i = 0; i < plv_pkg::ENTRIES; i++) begin
			if (cell_tok[i].vld && cell_tok[i].drop) begin
				drop_any  = 1'b1;
				drop_slot = drop_slot | cell_tok[i].hit_slot;
			end
		end
	end

	// Final result once the token has passed every cell.
	always_comb begin
		add_new    = 1'b0;
		fin_status = plv_pkg::ST_IGNORED;
		fin_slot   = '0;
		case (tail_q.mode)
			plv_pkg::MODE_HEARTBEAT: begin
				if (tail_q.found) begin
					fin_status = plv_pkg::ST_REFRESHED;
					fin_slot   = tail_q.hit_slot;
				end else if (tail_q.free) begin
					fin_status = plv_pkg::ST_ADDED;
					fin_slot   = tail_q.free_slot;
					add_new    = tail_q.vld;
				end else begin
					fin_status = plv_pkg::ST_FULL;
				end
			end
			plv_pkg::MODE_EXIT: begin
				if (tail_q.found) begin
					fin_status = plv_pkg::ST_EXIT_REMOVED;
					fin_slot   = tail_q.hit_slot;
				end else begin
					fin_status = plv_pkg::ST_EXIT_UNKNOWN;
				end
			end
			plv_pkg::MODE_SWEEP: fin_status = plv_pkg::ST_SWEEP_DONE;
			default:             fin_status = plv_pkg::ST_IGNORED;
		endcase
	end

	assign wr.addr_hi = tail_q.addr_hi;
	assign wr.addr_lo = tail_q.addr_lo;
	assign wr.now     = tail_q.now;

	always_comb begin
		wr_en = '0;
		if (advance && add_new)
			wr_en[tail_q.free_slot] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			busy_q    <= 1'b0;
			timeout_q <= plv_pkg::TIMEOUT_RST;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid)
				timeout_q <= cfg.timeout_seconds;
			if (accept) begin
				head_q.vld       <= 1'b1;
				head_q.mode      <= plv_pkg::mode_t'(req.mode);
				head_q.addr_hi   <= req.peer_addr_high;
				head_q.addr_lo   <= req.peer_addr_low;
				head_q.now       <= req.now_seconds;
				head_q.found     <= 1'b0;
				head_q.hit_slot  <= '0;
				head_q.free      <= 1'b0;
				head_q.free_slot <= '0;
				head_q.drop      <= 1'b0;
				busy_q           <= 1'b1;
			end else if (advance) begin
				head_q.vld <= 1'b0;
			end
			if (advance) begin
				tail_q    <= cell_tok[plv_pkg::ENTRIES-1];
				out_vld_q <= drop_any || tail_q.vld;
				if (tail_q.vld)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (drop_any) begin
				status_q <= plv_pkg::ST_DROPPED;
				slot_q   <= plv_pkg::SLOT_OUT_W'(drop_slot);
				last_q   <= 1'b0;
			end else begin
				status_q <= fin_status;
				slot_q   <= plv_pkg::SLOT_OUT_W'(fin_slot);
				last_q   <= 1'b1;
			end
		end
	end

	assign rsp.valid  = out_vld_q;
	assign rsp.status = status_q;
	assign rsp.slot   = slot_q;
	assign rsp.last   = last_q;

`ifndef SYNTHESIS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({head_q.vld, cell_vld, tail_q.vld}))
		else $error("more than one query token in the chain");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q.vld || (|cell_vld) || tail_q.vld) |-> busy_q)
		else $error("query token present while not busy");

	a_tail_done: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && tail_q.vld) |=> (!busy_q && out_vld_q && last_q))
		else $error("final result not issued when token left the chain");

	a_drop_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && status_q == plv_pkg::ST_DROPPED) |-> !last_q)
		else $error("drop result flagged as last");
`endif

endmodule

// ===== bench/peer_liveness_table_check.sv =====
// Checker for the peer liveness table: tracks the peer table and compares every result.
module peer_liveness_table_check
	import plv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	plv_req_if   req,
	plv_rsp_if   rsp,
	plv_cfg_if   cfg,
	output int   mismatches,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t               status;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  last;
	} outcome_t;

	outcome_t          awaited[$];
	logic              occupied [ENTRIES];
	logic [ADDR_W-1:0] peer_hi [ENTRIES];
	logic [ADDR_W-1:0] peer_lo [ENTRIES];
	logic [TIME_W-1:0] heard [ENTRIES];
	logic [TMO_W-1:0]  timeout_s;

	function automatic int slot_holding(logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo);
		for (int i = 0; i < ENTRIES; i++) begin
			if (occupied[i] && peer_hi[i] == hi && peer_lo[i] == lo) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int first_open_slot();
		for (int i = 0; i < ENTRIES; i++) begin
			if (!occupied[i]) begin
				return i;
			end
		end
		return -1;
	endfunction

	task automatic note(status_t st, int s, logic lst);
		outcome_t o;
		o.status = st;
		o.slot   = s[SLOT_OUT_W-1:0];
		o.last   = lst;
		awaited.push_back(o);
	endtask

	task automatic absorb_message(mode_t m, logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo,
		logic [TIME_W-1:0] now);
		int hit;
		case (m)
			MODE_HEARTBEAT: begin
				hit = slot_holding(hi, lo);
				if (hit >= 0) begin
					heard[hit] = now;
					note(ST_REFRESHED, hit, 1'b1);
				end else begin
					hit = first_open_slot();
					if (hit < 0) begin
						note(ST_FULL, 0, 1'b1);
					end else begin
						occupied[hit] = 1'b1;
						peer_hi[hit]  = hi;
						peer_lo[hit]  = lo;
						heard[hit]    = now;
						note(ST_ADDED, hit, 1'b1);
					end
				end
			end
			MODE_EXIT: begin
				hit = slot_holding(hi, lo);
				if (hit < 0) begin
					note(ST_EXIT_UNKNOWN, 0, 1'b1);
				end else begin
					occupied[hit] = 1'b0;
					note(ST_EXIT_REMOVED, hit, 1'b1);
				end
			end
			MODE_OTHER: begin
				note(ST_IGNORED, 0, 1'b1);
			end
			default: begin
				// no wrap: sum taken one bit wider than the time
				for (int i = 0; i < ENTRIES; i++) begin
					if (occupied[i] && ({1'b0, heard[i]} + (TIME_W+1)'(timeout_s))
						< {1'b0, now}) begin
						occupied[i] = 1'b0;
						note(ST_DROPPED, i, 1'b0);
					end
				end
				note(ST_SWEEP_DONE, 0, 1'b1);
			end
		endcase
	endtask

	task automatic compare_result(logic [2:0] st, logic [SLOT_OUT_W-1:0] sl, logic lst);
		outcome_t want;
		if (awaited.size() == 0) begin
			$error("result with no item pending: status %0d slot %0d last %0d", st, sl, lst);
			mismatches++;
			return;
		end
		want = awaited.pop_front();
		if (want.status != st) begin
			$error("status: expected %0d, got %0d", want.status, st);
			mismatches++;
		end
		if (want.slot != sl) begin
			$error("slot: expected %0d, got %0d", want.slot, sl);
			mismatches++;
		end
		if (want.last != lst) begin
			$error("last: expected %0d, got %0d", want.last, lst);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				occupied[i] = 1'b0;
			end
			timeout_s = TIMEOUT_RST;
			awaited.delete();
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				timeout_s = cfg.timeout_seconds;
			end
			if (rsp.valid && rsp.ready) begin
				compare_result(rsp.status, rsp.slot, rsp.last);
			end
			if (req.valid && req.ready) begin
				absorb_message(mode_t'(req.mode), req.peer_addr_high, req.peer_addr_low,
					req.now_seconds);
			end
			pending = awaited.size();
		end
	end

endmodule

// ===== bench/peer_liveness_table_test.sv =====
// Stimulus, flow control and verdict for the peer liveness table.
module peer_liveness_table_test;
	import plv_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int POOL        = 20;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int mismatches;
	int pending;
	int burst_left;
	int holds_asked;

	logic [ADDR_W-1:0] pool_hi [POOL];
	logic [ADDR_W-1:0] pool_lo [POOL];

	plv_req_if req ();
	plv_rsp_if rsp ();
	plv_cfg_if cfg ();

	peer_liveness_table dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	peer_liveness_table_check liveness_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offer one item, with a random gap whenever a burst runs out.
	task automatic offer_message(mode_t m, logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo,
		logic [TIME_W-1:0] now);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req.valid          <= 1'b1;
		req.mode           <= m;
		req.peer_addr_high <= hi;
		req.peer_addr_low  <= lo;
		req.now_seconds    <= now;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// Stop offering, wait for every expected result; optionally arm a long result stall.
	task automatic wait_drained(bit squeeze);
		req.valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		if (squeeze) begin
			holds_asked++;
		end
		@(posedge clk);
	endtask

	task automatic set_timeout(logic [TMO_W-1:0] secs);
		cfg.valid           <= 1'b1;
		cfg.timeout_seconds <= secs;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic run_traffic(logic [TMO_W-1:0] tmo, int count, bit squeeze);
		logic [TIME_W-1:0] clock_s;
		logic [ADDR_W-1:0] hi;
		logic [ADDR_W-1:0] lo;
		mode_t             m;
		int                pick;
		int                idx;
		int                step_max;
		int                sent;
		wait_drained(squeeze);
		set_timeout(tmo);
		clock_s  = $urandom;
		step_max = (tmo > 60) ? 30 : tmo / 2 + 2;
		sent     = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				m = MODE_HEARTBEAT;
			end else if (pick < 65) begin
				m = MODE_EXIT;
			end else if (pick < 90) begin
				m = MODE_SWEEP;
			end else begin
				m = MODE_OTHER;
			end
			// mostly known peers, now and then a stranger
			if ($urandom_range(0, 9) == 0) begin
				hi = {$urandom, $urandom};
				lo = {$urandom, $urandom};
			end else begin
				idx = $urandom_range(0, POOL - 1);
				hi  = pool_hi[idx];
				lo  = pool_lo[idx];
			end
			clock_s += $urandom_range(0, step_max);
			offer_message(m, hi, lo, clock_s);
			if (m != MODE_OTHER) begin
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		req.valid          = 1'b0;
		req.mode           = MODE_OTHER;
		req.peer_addr_high = '0;
		req.peer_addr_low  = '0;
		req.now_seconds    = '0;
		cfg.valid           = 1'b0;
		cfg.timeout_seconds = TIMEOUT_RST;
		burst_left  = 0;
		holds_asked = 0;
		pool_hi[0] = '0;
		pool_lo[0] = '0;
		pool_hi[1] = '1;
		pool_lo[1] = '1;
		for (int i = 2; i < POOL; i++) begin
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = {$urandom, $urandom};
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset timeout of 30 s
		offer_message(MODE_OTHER, '1, '1, '1);
		offer_message(MODE_EXIT, '0, '0, '0);
		offer_message(MODE_SWEEP, '0, '0, '0);
		offer_message(MODE_HEARTBEAT, pool_hi[0], pool_lo[0], 32'd0);
		offer_message(MODE_HEARTBEAT, pool_hi[1], pool_lo[1], 32'd0);
		offer_message(MODE_HEARTBEAT, pool_hi[0], pool_lo[0], 32'd5);
		offer_message(MODE_EXIT, pool_hi[1], pool_lo[1], 32'd6);
		for (int i = 2; i <= 16; i++) begin
			offer_message(MODE_HEARTBEAT, pool_hi[i], pool_lo[i], 32'd10);
		end
		offer_message(MODE_HEARTBEAT, pool_hi[17], pool_lo[17], 32'd10);
		// 5 + 30 equals 35: kept, the compare is strict
		offer_message(MODE_SWEEP, '0, '0, 32'd35);
		offer_message(MODE_SWEEP, '0, '0, '1);

		// largest timeout near the top of time: the sum must not wrap
		wait_drained(1'b0);
		set_timeout('1);
		offer_message(MODE_HEARTBEAT, pool_hi[0], pool_lo[0], 32'hFFFF_FFF0);
		offer_message(MODE_SWEEP, '0, '0, '1);

		wait_drained(1'b0);
		set_timeout('0);
		offer_message(MODE_HEARTBEAT, pool_hi[1], pool_lo[1], '1);
		offer_message(MODE_SWEEP, '0, '0, '1);

		run_traffic(TMO_W'($urandom_range(1, 60)), 14, 1'b1);
		run_traffic('1, 14, 1'b0);
		run_traffic(TMO_W'($urandom_range(2, 20)), 14, 1'b0);
		run_traffic('0, 14, 1'b1);
		run_traffic(TMO_W'($urandom_range(20, 90)), 14, 1'b0);

		wait_drained(1'b0);
		repeat (ENTRIES + 8) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("peer_liveness_table_test passed");
		end else begin
			$display("peer_liveness_table_test failed");
		end
		$finish;
	end

	// Result side: changing stall styles, plus a long hold-off when asked.
	initial begin : result_drain
		int cyc;
		int style;
		int holds_served;
		rsp.ready    = 1'b0;
		cyc          = 0;
		style        = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_served) begin
				holds_served++;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (cyc % 40 == 0) begin
				style = $urandom_range(0, 3);
			end
			cyc++;
			case (style)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= 1'($urandom_range(0, 1));
				2: rsp.ready <= ($urandom_range(0, 3) == 0);
				default: rsp.ready <= ((cyc / 8) % 2 == 0);
			endcase
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("peer_liveness_table_test failed");
		$finish;
	end

endmodule
